// ----- src/sist_pkg.sv -----
// ---------------------------------------------------------------------------
// sist_pkg
// shared word types and codes for the sorted integer set table
// ---------------------------------------------------------------------------
package sist_pkg;

  // command codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic [3:0]         read_index;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         position;
    logic signed [31:0] read_value;
    logic [4:0]         element_count;
    logic               is_empty;
  } rsp_t;

  // finish report from the sequencer to the output register
  typedef struct packed {
    logic               valid;
    logic [2:0]         status;
    logic [3:0]         position;
    logic signed [31:0] read_value;
  } fin_t;

endpackage

// ----- src/sist_core.sv -----
// ---------------------------------------------------------------------------
// sist_core
// entry memory with the scan / shift sequencer
// ---------------------------------------------------------------------------
module sist_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       start,
  input  sist_pkg::cmd_t                             cmd,
  input  logic [4:0]                                 capacity_limit,
  output logic                                       busy,
  output sist_pkg::fin_t                             fin,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]           count_next
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_INS_MV  = 3'd3;
  localparam logic [2:0] S_INS_PUT = 3'd4;
  localparam logic [2:0] S_REM_MV  = 3'd5;
  localparam logic [2:0] S_RD_WAIT = 3'd6;

  logic [2:0]           state, state_next;
  logic [CW-1:0]        count;
  logic [CW-1:0]        at, at_next;
  logic [CW-1:0]        j, j_next;
  logic                 found, found_next;
  sist_pkg::cmd_t       cmd_q;

  logic signed [31:0]   mem [TABLE_DEPTH];
  logic signed [31:0]   rd_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic signed [31:0]   wr_data;
  logic                 we;
  logic                 full;
  logic [CW:0]          j_plus2;

  assign busy    = (state != S_IDLE);
  assign full    = (32'(count) >= TABLE_DEPTH) || (32'(count) >= 32'(capacity_limit));
  assign j_plus2 = {1'b0, j} + (CW+1)'(2);

  always_comb begin
    state_next = state;
    count_next = count;
    at_next    = at;
    j_next     = j;
    found_next = found;
    rd_addr    = '0;
    we         = 1'b0;
    wr_addr    = AW'(j);
    wr_data    = rd_data;
    fin        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd.operation == sist_pkg::OP_READ) begin
            if (32'(cmd.read_index) < 32'(count)) begin
              rd_addr    = AW'(cmd.read_index);
              state_next = S_RD_WAIT;
            end else begin
              fin.valid  = 1'b1;
              fin.status = sist_pkg::ST_RANGE;
            end
          end else begin
            at_next    = '0;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rd_data holds entry 'at'
        if (at >= count) begin
          found_next = 1'b0;
          state_next = S_DECIDE;
        end else if (rd_data >= cmd_q.value) begin
          found_next = (rd_data == cmd_q.value);
          state_next = S_DECIDE;
        end else begin
          at_next = at + CW'(1);
          rd_addr = AW'(at + CW'(1));
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        case (cmd_q.operation)
          sist_pkg::OP_QUERY: begin
            fin.valid    = 1'b1;
            fin.status   = found ? sist_pkg::ST_DONE : sist_pkg::ST_ABSENT;
            fin.position = found ? 4'(at) : 4'd0;
          end
          sist_pkg::OP_INSERT: begin
            if (found) begin
              fin.valid    = 1'b1;
              fin.status   = sist_pkg::ST_PRESENT;
              fin.position = 4'(at);
            end else if (full) begin
              fin.valid  = 1'b1;
              fin.status = sist_pkg::ST_FULL;
            end else if (count == at) begin
              state_next = S_INS_PUT;
            end else begin
              rd_addr    = AW'(count - CW'(1));
              j_next     = count;
              state_next = S_INS_MV;
            end
          end
          sist_pkg::OP_REMOVE: begin
            if (!found) begin
              fin.valid  = 1'b1;
              fin.status = sist_pkg::ST_ABSENT;
            end else if ((at + CW'(1)) < count) begin
              rd_addr    = AW'(at + CW'(1));
              j_next     = at;
              state_next = S_REM_MV;
            end else begin
              fin.valid    = 1'b1;
              fin.status   = sist_pkg::ST_DONE;
              fin.position = 4'(at);
              count_next   = count - CW'(1);
            end
          end
          default: begin
            fin.valid  = 1'b1;
            fin.status = sist_pkg::ST_RANGE;
          end
        endcase
      end
      S_INS_MV: begin
        // move entry j-1 up to j
        we      = 1'b1;
        wr_addr = AW'(j);
        wr_data = rd_data;
        if ((j - CW'(1)) > at) begin
          rd_addr = AW'(j - CW'(2));
          j_next  = j - CW'(1);
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        we           = 1'b1;
        wr_addr      = AW'(at);
        wr_data      = cmd_q.value;
        count_next   = count + CW'(1);
        fin.valid    = 1'b1;
        fin.status   = sist_pkg::ST_DONE;
        fin.position = 4'(at);
        state_next   = S_IDLE;
      end
      S_REM_MV: begin
        // move entry j+1 down to j
        we      = 1'b1;
        wr_addr = AW'(j);
        wr_data = rd_data;
        if (j_plus2 < {1'b0, count}) begin
          rd_addr = AW'(j_plus2);
          j_next  = j + CW'(1);
        end else begin
          count_next   = count - CW'(1);
          fin.valid    = 1'b1;
          fin.status   = sist_pkg::ST_DONE;
          fin.position = 4'(at);
          state_next   = S_IDLE;
        end
      end
      S_RD_WAIT: begin
        fin.valid      = 1'b1;
        fin.status     = sist_pkg::ST_DONE;
        fin.read_value = rd_data;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    at    <= at_next;
    j     <= j_next;
    found <= found_next;
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/sorted_integer_set_table_unit.sv -----
// ---------------------------------------------------------------------------
// sorted_integer_set_table_unit
// bounded set of distinct signed 32-bit words kept in ascending order
// ---------------------------------------------------------------------------
// command flow: a read fetches the entry at the index and reports it, and an index
//   out of range is reported without a memory read; other commands scan up from
//   the lowest entry to the sorted position p where the scan stops, then decide;
//   insert shifts the entries above p up and writes the word, remove shifts down
// one command at a time, set by the linear scan and shift through the entry memory
// results cannot be stalled: done pulses for one cycle with the result word
// reset: set empty, capacity_limit 16; memory contents are not cleared
module sorted_integer_set_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  // command word
  input  logic           start,
  input  sist_pkg::cmd_t cmd,
  output logic           busy,
  // configuration
  input  logic           cfg_we,
  input  logic [4:0]     cfg_data,
  // result word
  output logic           done,
  output sist_pkg::rsp_t result
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                 capacity_we;
  logic [4:0]           capacity_limit;
  sist_pkg::fin_t       fin;
  logic [CW-1:0]        count_next;

  assign capacity_we = cfg_we;

  // capacity register, reset to the full table of sixteen
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= 5'd16;
    end else if (capacity_we) begin
      capacity_limit <= cfg_data;
    end
  end

  // scan and shift sequencer around the entry memory
  sist_core #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .cmd            (cmd),
    .capacity_limit (capacity_limit),
    .busy           (busy),
    .fin            (fin),
    .count_next     (count_next)
  );

  // output register: the result word with the element count after the command
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      result.status        <= fin.status;
      result.position      <= fin.position;
      result.read_value    <= fin.read_value;
      result.element_count <= 5'(count_next);
      result.is_empty      <= (count_next == '0);
    end
  end

endmodule
